// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the text overlay block.
// Define NO_ASSERTIONS to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, held off while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, held off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tog_pkg.sv =====
// Types, constants and the glyph ROM of the text overlay pixel generator.
// No dependencies; used by text_overlay_pixel_generator_core.
`default_nettype none

package tog_pkg;

  // Screen and font geometry.
  localparam int SCREEN_WIDTH = 320;
  localparam int TEXT_SCALE   = 4;
  localparam int MAX_CHARS    = 16;
  localparam int TEXT_LINES   = 4;
  localparam int GLYPH_PITCH  = 6;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_BITS   = 5;
  localparam int GLYPH_ROWS   = 7;
  localparam int CELL_W       = GLYPH_PITCH * TEXT_SCALE;
  localparam int BOX_H        = GLYPH_ROWS * TEXT_SCALE;

  // Moving bar.
  localparam int BAR_TOP     = 214;
  localparam int BAR_BOTTOM  = 224;
  localparam int BAR_WIDTH   = 56;
  localparam int BAR_MARGIN  = 18;
  localparam int BAR_TRAVEL  = SCREEN_WIDTH - (BAR_WIDTH + 2 * BAR_MARGIN);

  // Port field widths.
  localparam int CMD_W   = 2;
  localparam int LINE_W  = 2;
  localparam int POS_W   = 4;
  localparam int CODE_W  = 8;
  localparam int TOP_W   = 8;
  localparam int COLOR_W = 16;
  localparam int LEN_W   = 5;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int TICK_W  = 32;

  // Internal widths.
  localparam int XOFF_W   = X_W + 2;                  // signed line origin and x - origin
  localparam int XREL_W   = XOFF_W - 1;               // non-negative x - origin
  localparam int YREL_W   = Y_W + 1;                  // signed y - top
  localparam int ROW_W    = $clog2(GLYPH_ROWS);
  localparam int COL_W    = $clog2(GLYPH_PITCH);
  localparam int REM_W    = $clog2(CELL_W);
  localparam int IDX_W    = $clog2((2 ** XREL_W) / CELL_W + 1);
  localparam int IDX_SHIFT = 16;
  localparam int IDX_RECIP = (2 ** IDX_SHIFT) / CELL_W + 1;
  localparam int IDX_PROD_W = XREL_W + IDX_SHIFT;

  // tick / BAR_TRAVEL by a floor reciprocal; the estimate is low by at most one.
  localparam logic [TICK_W-1:0] TICK_RECIP = TICK_W'((64'd1 << TICK_W) / BAR_TRAVEL);
  localparam int BAR_Q_W   = $clog2(TICK_RECIP);
  localparam int BAR_RAW_W = $clog2(2 * BAR_TRAVEL);
  localparam int BAR_R_W   = $clog2(BAR_TRAVEL);
  localparam int BAR_X_W   = X_W + 1;

  localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;
  localparam logic [COLOR_W-1:0] COLOR_CYAN  = 16'h07FF;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_CHAR = 2'd0,
    CMD_SET_LINE   = 2'd1,
    CMD_RENDER     = 2'd2
  } cmd_t;

  // Leftmost column of a centered line; negative when the line is wider than the screen.
  function automatic logic signed [XOFF_W-1:0] line_x0(input logic [LEN_W-1:0] len);
    int span;
    span = int'(len) * CELL_W - TEXT_SCALE;
    return XOFF_W'((SCREEN_WIDTH - span) / 2);
  endfunction

  // One glyph column; bit 0 is the top row. Codes without a glyph are blank.
  function automatic logic [GLYPH_BITS-1:0] glyph_column(input logic [CODE_W-1:0] code,
                                                         input logic [COL_W-1:0] col);
    logic [GLYPH_COLS*GLYPH_BITS-1:0] g;
    // Packed with column 4 on the left and column 0 on the right.
    case (code)
      8'h30: g = {5'h19, 5'h15, 5'h13, 5'h11, 5'h0E};  // 0
      8'h31: g = {5'h00, 5'h00, 5'h1F, 5'h01, 5'h00};  // 1
      8'h32: g = {5'h12, 5'h15, 5'h15, 5'h15, 5'h19};  // 2
      8'h33: g = {5'h0A, 5'h15, 5'h15, 5'h15, 5'h11};  // 3
      8'h34: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h07};  // 4
      8'h35: g = {5'h09, 5'h15, 5'h15, 5'h15, 5'h17};  // 5
      8'h36: g = {5'h08, 5'h15, 5'h15, 5'h15, 5'h0E};  // 6
      8'h37: g = {5'h1F, 5'h10, 5'h10, 5'h10, 5'h10};  // 7
      8'h38: g = {5'h0A, 5'h15, 5'h15, 5'h15, 5'h0A};  // 8
      8'h39: g = {5'h0E, 5'h15, 5'h15, 5'h15, 5'h02};  // 9
      8'h41: g = {5'h1E, 5'h05, 5'h05, 5'h05, 5'h1E};  // A
      8'h42: g = {5'h0A, 5'h15, 5'h15, 5'h15, 5'h1F};  // B
      8'h43: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};  // C
      8'h44: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h1F};  // D
      8'h45: g = {5'h11, 5'h15, 5'h15, 5'h15, 5'h1F};  // E
      8'h46: g = {5'h01, 5'h05, 5'h05, 5'h05, 5'h1F};  // F
      8'h47: g = {5'h1D, 5'h15, 5'h15, 5'h11, 5'h0E};  // G
      8'h48: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F};  // H
      8'h49: g = {5'h00, 5'h00, 5'h11, 5'h1F, 5'h11};  // I
      8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};  // L
      8'h4D: g = {5'h1F, 5'h02, 5'h0C, 5'h02, 5'h1F};  // M
      8'h4E: g = {5'h1F, 5'h08, 5'h04, 5'h02, 5'h1F};  // N
      8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};  // O
      8'h50: g = {5'h02, 5'h05, 5'h05, 5'h05, 5'h1F};  // P
      8'h52: g = {5'h12, 5'h15, 5'h0D, 5'h05, 5'h1F};  // R
      8'h53: g = {5'h09, 5'h15, 5'h15, 5'h15, 5'h12};  // S
      8'h54: g = {5'h01, 5'h01, 5'h1F, 5'h01, 5'h01};  // T
      8'h55: g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F};  // U
      8'h56: g = {5'h07, 5'h08, 5'h10, 5'h08, 5'h07};  // V
      8'h57: g = {5'h1F, 5'h08, 5'h04, 5'h08, 5'h1F};  // W
      8'h58: g = {5'h1B, 5'h04, 5'h04, 5'h04, 5'h1B};  // X
      8'h59: g = {5'h03, 5'h04, 5'h18, 5'h04, 5'h03};  // Y
      8'h5A: g = {5'h11, 5'h11, 5'h13, 5'h15, 5'h19};  // Z
      8'h2D: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04};  // minus
      8'h3A: g = {5'h00, 5'h0A, 5'h00, 5'h0A, 5'h00};  // colon
      8'h2F: g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10};  // slash
      8'h2E: g = {5'h0C, 5'h0C, 5'h00, 5'h00, 5'h00};  // period
      default: g = '0;
    endcase
    case (col)
      3'd0:    return g[0*GLYPH_BITS +: GLYPH_BITS];
      3'd1:    return g[1*GLYPH_BITS +: GLYPH_BITS];
      3'd2:    return g[2*GLYPH_BITS +: GLYPH_BITS];
      3'd3:    return g[3*GLYPH_BITS +: GLYPH_BITS];
      3'd4:    return g[4*GLYPH_BITS +: GLYPH_BITS];
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tog_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; the contents are undefined until written.
`default_nettype none

module tog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read and a write to the same address in one cycle return the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/text_overlay_pixel_generator_core.sv =====
// Top level of the text overlay pixel generator: command decode, line attributes,
// render pipeline and one tog_ram per text line. Uses tog_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The block takes one command word on every clock in which start is high; busy
// is always low. Write-character and set-line words produce no result. A render
// word produces exactly one pixel color on out_pixel_color with out_valid high
// for one cycle, registered at the end of the pipeline, so results
// leave in the order their renders came in. The rate is one word per clock, set by a
// four-stage pipeline: attribute lookup and the tick reciprocal multiply, the
// character index multiply, the text memory read, then glyph and color select.
// Every word sees the effect of all words taken before it. Character memory is
// not cleared at reset; line lengths reset to zero, so all lines start empty.
module text_overlay_pixel_generator_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [tog_pkg::CMD_W-1:0]      in_command,
  input  wire logic [tog_pkg::LINE_W-1:0]     in_line_select,
  input  wire logic [tog_pkg::POS_W-1:0]      in_char_pos,
  input  wire logic [tog_pkg::CODE_W-1:0]     in_char_code,
  input  wire logic [tog_pkg::TOP_W-1:0]      in_top_row,
  input  wire logic [tog_pkg::COLOR_W-1:0]    in_text_color,
  input  wire logic [tog_pkg::LEN_W-1:0]      in_text_length,
  input  wire logic [tog_pkg::X_W-1:0]        in_pixel_x,
  input  wire logic [tog_pkg::Y_W-1:0]        in_pixel_y,
  input  wire logic [tog_pkg::TICK_W-1:0]     in_tick,
  output logic                                out_valid,
  output logic      [tog_pkg::COLOR_W-1:0]    out_pixel_color
);

  localparam int NL = tog_pkg::TEXT_LINES;

  typedef struct packed {
    logic [tog_pkg::X_W-1:0] x;
    logic                    offscreen;
    logic                    bar_rows;
  } pix_t;

  typedef struct packed {
    logic [tog_pkg::LINE_W-1:0] line;
    logic [tog_pkg::POS_W-1:0]  pos;
    logic [tog_pkg::CODE_W-1:0] code;
  } wr_t;

  logic accept;
  logic render_in;
  logic write_in;
  logic set_in;

  // Line attributes.
  logic        [tog_pkg::TOP_W-1:0]   top_r   [NL];
  logic        [tog_pkg::COLOR_W-1:0] color_r [NL];
  logic        [tog_pkg::LEN_W-1:0]   len_r   [NL];
  logic signed [tog_pkg::XOFF_W-1:0]  x0_r    [NL];
  logic        [tog_pkg::LEN_W-1:0]   len_sat;

  // Input side.
  logic signed [tog_pkg::XOFF_W-1:0]  rel_x   [NL];
  logic signed [tog_pkg::YREL_W-1:0]  rel_y   [NL];
  logic                               in_ok   [NL];
  logic        [2*tog_pkg::TICK_W-1:0] tick_prod;
  pix_t                               pix_in;
  wr_t                                wr_in;

  // Stage 1.
  logic                               s1_v_r, s1_wv_r;
  pix_t                               s1_pix_r;
  wr_t                                s1_wr_r;
  logic        [tog_pkg::TICK_W-1:0]  s1_tick_r;
  logic        [tog_pkg::BAR_Q_W-1:0] s1_q_r;
  logic        [tog_pkg::XREL_W-1:0]  s1_relx_r  [NL];
  logic        [tog_pkg::ROW_W-1:0]   s1_row_r   [NL];
  logic                               s1_ok_r    [NL];
  logic        [tog_pkg::LEN_W-1:0]   s1_len_r   [NL];
  logic        [tog_pkg::COLOR_W-1:0] s1_color_r [NL];
  logic        [tog_pkg::IDX_PROD_W-1:0] idx_prod [NL];
  logic        [tog_pkg::TICK_W-1:0]  bar_full;

  // Stage 2.
  logic                               s2_v_r, s2_wv_r;
  pix_t                               s2_pix_r;
  wr_t                                s2_wr_r;
  logic        [tog_pkg::BAR_RAW_W-1:0] s2_bar_raw_r;
  logic        [tog_pkg::IDX_W-1:0]   s2_idx_r   [NL];
  logic        [tog_pkg::XREL_W-1:0]  s2_relx_r  [NL];
  logic        [tog_pkg::ROW_W-1:0]   s2_row_r   [NL];
  logic                               s2_ok_r    [NL];
  logic        [tog_pkg::LEN_W-1:0]   s2_len_r   [NL];
  logic        [tog_pkg::COLOR_W-1:0] s2_color_r [NL];
  logic        [tog_pkg::REM_W-1:0]   rem        [NL];
  logic        [tog_pkg::COL_W-1:0]   col        [NL];
  logic                               cell_ok    [NL];
  logic        [tog_pkg::BAR_R_W-1:0] bar_r;

  // Stage 3.
  logic                               s3_v_r;
  pix_t                               s3_pix_r;
  logic        [tog_pkg::BAR_R_W-1:0] s3_bar_r;
  logic        [tog_pkg::COL_W-1:0]   s3_col_r   [NL];
  logic        [tog_pkg::ROW_W-1:0]   s3_row_r   [NL];
  logic                               s3_ok_r    [NL];
  logic        [tog_pkg::COLOR_W-1:0] s3_color_r [NL];
  logic        [tog_pkg::CODE_W-1:0]  s3_code    [NL];
  logic        [tog_pkg::GLYPH_BITS-1:0] bits    [NL];
  logic                               line_hit   [NL];
  logic        [tog_pkg::BAR_X_W-1:0] bar_x;
  logic        [tog_pkg::BAR_X_W-1:0] x_ext;
  logic                               bar_hit;
  logic        [tog_pkg::COLOR_W-1:0] pix_color;

  // Output register.
  logic                               out_valid_r;
  logic        [tog_pkg::COLOR_W-1:0] out_color_r;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign render_in = accept && (in_command == tog_pkg::CMD_RENDER);
  assign write_in  = accept && (in_command == tog_pkg::CMD_WRITE_CHAR) &&
                     (in_line_select < tog_pkg::TEXT_LINES) &&
                     (in_char_pos < tog_pkg::MAX_CHARS);
  assign set_in    = accept && (in_command == tog_pkg::CMD_SET_LINE) &&
                     (in_line_select < tog_pkg::TEXT_LINES);
  assign len_sat   = (in_text_length > tog_pkg::MAX_CHARS) ?
                     tog_pkg::LEN_W'(tog_pkg::MAX_CHARS) : in_text_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NL; l++) begin
        top_r[l]   <= '0;
        color_r[l] <= '0;
        len_r[l]   <= '0;
        x0_r[l]    <= tog_pkg::line_x0('0);
      end
    end else if (set_in) begin
      top_r[in_line_select]   <= in_top_row;
      color_r[in_line_select] <= in_text_color;
      len_r[in_line_select]   <= len_sat;
      x0_r[in_line_select]    <= tog_pkg::line_x0(len_sat);
    end
  end

  // Render words read the attributes at the edge that takes them, so a later
  // set-line word cannot reach a render already in flight.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rel_x[l] = $signed({2'b00, in_pixel_x}) - x0_r[l];
      rel_y[l] = $signed({1'b0, in_pixel_y}) - $signed({1'b0, top_r[l]});
      in_ok[l] = (len_r[l] != '0) && !rel_y[l][tog_pkg::YREL_W-1] &&
                 (rel_y[l][tog_pkg::Y_W-1:0] < tog_pkg::Y_W'(tog_pkg::BOX_H)) &&
                 !rel_x[l][tog_pkg::XOFF_W-1];
    end
    tick_prod = {{tog_pkg::TICK_W{1'b0}}, in_tick} *
                {{tog_pkg::TICK_W{1'b0}}, tog_pkg::TICK_RECIP};
    pix_in.x         = in_pixel_x;
    pix_in.offscreen = (in_pixel_x >= tog_pkg::X_W'(tog_pkg::SCREEN_WIDTH));
    pix_in.bar_rows  = (in_pixel_y >= tog_pkg::Y_W'(tog_pkg::BAR_TOP)) &&
                       (in_pixel_y <= tog_pkg::Y_W'(tog_pkg::BAR_BOTTOM));
    wr_in.line = in_line_select;
    wr_in.pos  = in_char_pos;
    wr_in.code = in_char_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s1_wv_r <= 1'b0;
    end else begin
      s1_v_r  <= render_in;
      s1_wv_r <= write_in;
    end
    s1_pix_r  <= pix_in;
    s1_wr_r   <= wr_in;
    s1_tick_r <= in_tick;
    s1_q_r    <= tog_pkg::BAR_Q_W'(tick_prod >> tog_pkg::TICK_W);
    for (int l = 0; l < NL; l++) begin
      s1_relx_r[l]  <= rel_x[l][tog_pkg::XREL_W-1:0];
      s1_row_r[l]   <= tog_pkg::ROW_W'(rel_y[l][tog_pkg::Y_W-1:0] / tog_pkg::TEXT_SCALE);
      s1_ok_r[l]    <= in_ok[l];
      s1_len_r[l]   <= len_r[l];
      s1_color_r[l] <= color_r[l];
    end
  end

  // Stage 1: character index by reciprocal, and the uncorrected tick remainder.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      idx_prod[l] = tog_pkg::IDX_PROD_W'(s1_relx_r[l]) *
                    tog_pkg::IDX_PROD_W'(tog_pkg::IDX_RECIP);
    end
    bar_full = s1_tick_r - (tog_pkg::TICK_W'(s1_q_r) * tog_pkg::TICK_W'(tog_pkg::BAR_TRAVEL));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s2_wv_r <= 1'b0;
    end else begin
      s2_v_r  <= s1_v_r;
      s2_wv_r <= s1_wv_r;
    end
    s2_pix_r     <= s1_pix_r;
    s2_wr_r      <= s1_wr_r;
    s2_bar_raw_r <= bar_full[tog_pkg::BAR_RAW_W-1:0];
    for (int l = 0; l < NL; l++) begin
      s2_idx_r[l]   <= tog_pkg::IDX_W'(idx_prod[l] >> tog_pkg::IDX_SHIFT);
      s2_relx_r[l]  <= s1_relx_r[l];
      s2_row_r[l]   <= s1_row_r[l];
      s2_ok_r[l]    <= s1_ok_r[l];
      s2_len_r[l]   <= s1_len_r[l];
      s2_color_r[l] <= s1_color_r[l];
    end
  end

  // Stage 2: glyph column inside the cell, memory address, bar remainder fix-up.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rem[l] = tog_pkg::REM_W'(s2_relx_r[l] -
               tog_pkg::XREL_W'(s2_idx_r[l] * tog_pkg::CELL_W));
      col[l] = tog_pkg::COL_W'(rem[l] / tog_pkg::TEXT_SCALE);
      cell_ok[l] = s2_ok_r[l] && (s2_idx_r[l] < tog_pkg::IDX_W'(s2_len_r[l])) &&
                   (col[l] < tog_pkg::COL_W'(tog_pkg::GLYPH_COLS));
    end
    if (s2_bar_raw_r >= tog_pkg::BAR_RAW_W'(tog_pkg::BAR_TRAVEL)) begin
      bar_r = tog_pkg::BAR_R_W'(s2_bar_raw_r - tog_pkg::BAR_RAW_W'(tog_pkg::BAR_TRAVEL));
    end else begin
      bar_r = tog_pkg::BAR_R_W'(s2_bar_raw_r);
    end
  end

  // Character writes reach the memory at the same stage where renders read it,
  // which keeps the word order between the two.
  for (genvar l = 0; l < NL; l++) begin : g_line
    tog_ram #(
      .WIDTH(tog_pkg::CODE_W),
      .DEPTH(tog_pkg::MAX_CHARS)
    ) u_text (
      .clk  (clk),
      .we   (s2_wv_r && (s2_wr_r.line == tog_pkg::LINE_W'(l))),
      .waddr(s2_wr_r.pos),
      .wdata(s2_wr_r.code),
      .raddr(s2_idx_r[l][tog_pkg::POS_W-1:0]),
      .rdata(s3_code[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_pix_r <= s2_pix_r;
    s3_bar_r <= bar_r;
    for (int l = 0; l < NL; l++) begin
      s3_col_r[l]   <= col[l];
      s3_row_r[l]   <= s2_row_r[l];
      s3_ok_r[l]    <= cell_ok[l];
      s3_color_r[l] <= s2_color_r[l];
    end
  end

  // Stage 3: glyph lookup, line priority, bar and screen edge.
  always_comb begin
    pix_color = tog_pkg::COLOR_BLACK;
    for (int l = 0; l < NL; l++) begin
      bits[l]     = tog_pkg::glyph_column(s3_code[l], s3_col_r[l]);
      line_hit[l] = s3_ok_r[l] && (s3_row_r[l] < tog_pkg::ROW_W'(tog_pkg::GLYPH_BITS)) &&
                    bits[l][s3_row_r[l]];
      if (line_hit[l]) begin
        pix_color = s3_color_r[l];
      end
    end
    bar_x   = tog_pkg::BAR_X_W'(tog_pkg::BAR_MARGIN) + tog_pkg::BAR_X_W'(s3_bar_r);
    x_ext   = tog_pkg::BAR_X_W'(s3_pix_r.x);
    bar_hit = s3_pix_r.bar_rows && (x_ext >= bar_x) &&
              (x_ext < bar_x + tog_pkg::BAR_X_W'(tog_pkg::BAR_WIDTH));
    if (bar_hit) begin
      pix_color = tog_pkg::COLOR_CYAN;
    end
    if (s3_pix_r.offscreen) begin
      pix_color = tog_pkg::COLOR_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_v_r;
    end
    out_color_r <= pix_color;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;

  `ASSERT_IMPLIES(a_bar_raw_range, clk, rst_n, s2_v_r, s2_bar_raw_r < 2 * tog_pkg::BAR_TRAVEL)
  `ASSERT_IMPLIES(a_bar_pos_range, clk, rst_n, s3_v_r, s3_bar_r < tog_pkg::BAR_TRAVEL)
  `ASSERT_NEXT(a_offscreen_black, clk, rst_n, s3_v_r && s3_pix_r.offscreen, out_valid && out_pixel_color == tog_pkg::COLOR_BLACK)
  `ASSERT_NEXT(a_bar_cyan, clk, rst_n, s3_v_r && !s3_pix_r.offscreen && bar_hit, out_pixel_color == tog_pkg::COLOR_CYAN)
  `ASSERT_NEXT(a_no_stray_word, clk, rst_n, !s3_v_r, !out_valid)

endmodule

`default_nettype wire
